>>> rtl/rgbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL package
// Pixel and result beat types and shared constants.
// ----------------------------------------------------------------------------
package rgbh_pkg;

	localparam int unsigned COMP_W = 8;
	localparam int unsigned HUE_W = 15;
	localparam int unsigned UNIT_W = 16;
	localparam int unsigned HUE_SECTOR = 3840;
	localparam int unsigned HUE_TURN = 23040;
	localparam int unsigned UNIT_ONE = 65535;

	typedef struct packed {
		logic [COMP_W-1:0] red_in;
		logic [COMP_W-1:0] green_in;
		logic [COMP_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_out;
		logic [UNIT_W-1:0] saturation_out;
		logic [UNIT_W-1:0] lightness_out;
	} hsl_t;

endpackage
`default_nettype wire

>>> rtl/rgbh_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit per cell; the partial remainder moves to the next cell.
// ----------------------------------------------------------------------------
module rgbh_div_cell #(
	parameter int unsigned REM_W = 10,
	parameter int unsigned DIV_W = 9,
	parameter int unsigned NUM_W = 16,
	parameter int unsigned Q_W = 16,
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_in,
	input  wire logic [REM_W-1:0]  rem_in,
	input  wire logic [DIV_W-1:0]  dvs_in,
	input  wire logic [NUM_W-1:0]  num_in,
	input  wire logic [Q_W-1:0]    quo_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output logic [REM_W-1:0]       rem_out,
	output logic [DIV_W-1:0]       dvs_out,
	output logic [NUM_W-1:0]       num_out,
	output logic [Q_W-1:0]         quo_out,
	output logic [SIDE_W-1:0]      side_out
);

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           fits;

	assign trial = {rem_in, num_in[NUM_W-1]};
	assign diff = trial - {{(REM_W+1-DIV_W){1'b0}}, dvs_in};
	assign fits = !diff[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
		dvs_out <= dvs_in;
		num_out <= {num_in[NUM_W-2:0], 1'b0};
		quo_out <= {quo_in[Q_W-2:0], fits};
		side_out <= side_in;
	end

endmodule
`default_nettype wire

>>> rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL converter
// The start beat passes the input register, the divider cells and the output register before the result strobe.
// One pixel is accepted every cycle; busy is always low.
// The depth is set by the chain of 16 divider cells, one quotient bit each.
// Reset clears all valid flags; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rgbh_pkg::pixel_t pixel,
	output logic                 strobe,
	output rgbh_pkg::hsl_t       result
);

	localparam int unsigned NC = 16;
	localparam int unsigned DW = 9;
	localparam int unsigned RW = 10;
	localparam int unsigned NW = 16;
	localparam int unsigned SW = 2 + 15 + 1 + 9;

	typedef struct packed {
		logic [1:0]  sector;
		logic [14:0] base;
		logic        neg;
		logic [8:0]  sum;
	} side_t;

	logic [7:0] r, g, b, mx, mn, dl, pos, ng;
	logic [8:0] sum, den;
	logic [1:0] sec;

	logic       v_s1;
	logic [7:0] dl_s1, dh_s1;
	logic [8:0] den_s1, sum_s1;
	logic [1:0] sec_s1;
	logic       neg_s1;

	logic [19:0] hnum;
	logic [23:0] snum;

	logic [NC:0]        hv, sv;
	logic [RW-1:0]      hr [NC+1], sr [NC+1];
	logic [DW-1:0]      hd [NC+1], sd [NC+1];
	logic [NW-1:0]      hn [NC+1], sn [NC+1];
	logic [NW-1:0]      hq [NC+1], sq [NC+1];
	logic [SW-1:0]      hs [NC+1], ss [NC+1];
	side_t              side0, sidef;

	assign busy = 1'b0;
	assign r = pixel.red_in;
	assign g = pixel.green_in;
	assign b = pixel.blue_in;

	always_comb begin
		mx = r; sec = 2'd0; pos = g; ng = b;
		if (g > mx) begin mx = g; sec = 2'd1; pos = b; ng = r; end
		if (b > mx) begin mx = b; sec = 2'd2; pos = r; ng = g; end
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		den = (sum <= 9'd255) ? sum : 9'd510 - sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dl_s1 <= dl;
		dh_s1 <= (pos >= ng) ? pos - ng : ng - pos;
		neg_s1 <= pos < ng;
		den_s1 <= den;
		sum_s1 <= sum;
		sec_s1 <= sec;
	end

	// Quotients fit in 16 bits: 3840*diff/delta <= 3840 and delta*65535/den <= 65535.
	// The high numerator bits are preloaded into the remainder.
	assign hnum = 20'(dh_s1) * 20'd3840;
	assign snum = 24'(dl_s1) * 24'd65535;
	assign side0 = '{sector: sec_s1, base: 15'(sec_s1) * 15'd7680, neg: neg_s1, sum: sum_s1};

	assign hv[0] = v_s1;
	assign hr[0] = RW'(hnum[19:16]);
	assign hd[0] = {1'b0, dl_s1};
	assign hn[0] = hnum[15:0];
	assign hq[0] = '0;
	assign hs[0] = side0;
	assign sv[0] = v_s1;
	assign sr[0] = RW'(snum[23:16]);
	assign sd[0] = den_s1;
	assign sn[0] = snum[15:0];
	assign sq[0] = '0;
	assign ss[0] = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cells
		rgbh_div_cell #(.REM_W(RW), .DIV_W(DW), .NUM_W(NW), .Q_W(NW), .SIDE_W(SW)) u_h (
			.clk, .arst_n, .vld_in(hv[i]), .rem_in(hr[i]), .dvs_in(hd[i]),
			.num_in(hn[i]), .quo_in(hq[i]), .side_in(hs[i]),
			.vld_out(hv[i+1]), .rem_out(hr[i+1]), .dvs_out(hd[i+1]),
			.num_out(hn[i+1]), .quo_out(hq[i+1]), .side_out(hs[i+1]));
		rgbh_div_cell #(.REM_W(RW), .DIV_W(DW), .NUM_W(NW), .Q_W(NW), .SIDE_W(SW)) u_s (
			.clk, .arst_n, .vld_in(sv[i]), .rem_in(sr[i]), .dvs_in(sd[i]),
			.num_in(sn[i]), .quo_in(sq[i]), .side_in(ss[i]),
			.vld_out(sv[i+1]), .rem_out(sr[i+1]), .dvs_out(sd[i+1]),
			.num_out(sn[i+1]), .quo_out(sq[i+1]), .side_out(ss[i+1]));
	end

	assign sidef = hs[NC];

	logic [15:0] hmag, hue_v, lig_v;
	logic [16:0] lt;
	always_comb begin
		hmag = hq[NC];
		if (hd[NC] == '0) hue_v = '0;
		else if (!sidef.neg) hue_v = 16'(sidef.base) + hmag;
		else if (hmag > 16'(sidef.base)) hue_v = 16'(sidef.base) + 16'd23040 - hmag;
		else hue_v = 16'(sidef.base) - hmag;
		if (hue_v >= 16'd23040) hue_v = hue_v - 16'd23040;
		// Since 65535/510 is 128.5, lightness is sum*128 plus half the sum, rounded down.
		lt = 17'({sidef.sum, 7'd0}) + 17'(sidef.sum[8:1]);
		lig_v = lt[15:0] | {16{lt[16]}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= hv[NC];
	end

	always_ff @(posedge clk) begin
		result.hue_out <= hue_v[14:0];
		result.saturation_out <= (hd[NC] == '0) ? 16'd0 : sq[NC];
		result.lightness_out <= lig_v;
	end

	logic unused_l;
	assign unused_l = ^{sv[NC], sr[NC], sd[NC], sn[NC], ss[NC], hr[NC], hn[NC]};

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n) hv[NC] == sv[NC])
		else $error("divider lanes out of step");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n) v_s1 |-> ##17 strobe)
		else $error("result strobe missing");
	a_hue: assert property (@(posedge clk) disable iff (!arst_n) strobe |-> result.hue_out < 15'd23040)
		else $error("hue out of range");
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives a table of directed pixels, then pixels in random bursts, predicts
// hue, saturation and lightness for each accepted pixel, and checks every
// result strobe against the oldest prediction in order.
module tb_top;

	localparam int unsigned FULL = 255;
	localparam int unsigned N_RANDOM = 650;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct {
		rgbh_pkg::pixel_t pix;
		logic             known;
		rgbh_pkg::hsl_t   hsl;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	rgbh_pkg::pixel_t pixel;
	logic             strobe;
	rgbh_pkg::hsl_t   result;

	rgbh_pkg::hsl_t hsl_pending[$];
	stim_row_t      stim_table[$];
	int             error_count;
	int             idle_cycles = 0;

	rgb_to_hsl_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [14:0] hue_of(int unsigned base, int unsigned pos,
			int unsigned neg, int unsigned delta);
		int unsigned mag;
		int unsigned h;
		if (pos >= neg) begin
			h = base + (rgbh_pkg::HUE_SECTOR * (pos - neg)) / delta;
		end else begin
			mag = (rgbh_pkg::HUE_SECTOR * (neg - pos)) / delta;
			h = (mag > base) ? base + rgbh_pkg::HUE_TURN - mag : base - mag;
		end
		if (h >= rgbh_pkg::HUE_TURN) begin
			h = h - rgbh_pkg::HUE_TURN;
		end
		return h[14:0];
	endfunction

	function automatic rgbh_pkg::hsl_t convert_pixel(rgbh_pkg::pixel_t p);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		int unsigned mx;
		int unsigned mn;
		int unsigned delta;
		int unsigned sum;
		int unsigned denom;
		int unsigned sat;
		int unsigned lig;
		rgbh_pkg::hsl_t o;
		r = 32'(p.red_in);
		g = 32'(p.green_in);
		b = 32'(p.blue_in);
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		sum = mx + mn;
		o.hue_out = '0;
		sat = 0;
		if (delta > 0) begin
			if (mx == r) o.hue_out = hue_of(0, g, b, delta);
			else if (mx == g) o.hue_out = hue_of(2 * rgbh_pkg::HUE_SECTOR, b, r, delta);
			else o.hue_out = hue_of(4 * rgbh_pkg::HUE_SECTOR, r, g, delta);
			denom = (sum <= FULL) ? sum : 2 * FULL - sum;
			if (denom != 0) begin
				sat = (delta * rgbh_pkg::UNIT_ONE) / denom;
				if (sat > rgbh_pkg::UNIT_ONE) sat = rgbh_pkg::UNIT_ONE;
			end
		end
		lig = (sum * rgbh_pkg::UNIT_ONE) / (2 * FULL);
		if (lig > rgbh_pkg::UNIT_ONE) lig = rgbh_pkg::UNIT_ONE;
		o.saturation_out = sat[15:0];
		o.lightness_out = lig[15:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic known,
			int unsigned h, int unsigned s, int unsigned l);
		stim_row_t row;
		row.pix = '{red_in: r, green_in: g, blue_in: b};
		row.known = known;
		row.hsl = '{hue_out: h[14:0], saturation_out: s[15:0], lightness_out: l[15:0]};
		stim_table.push_back(row);
	endtask

	task automatic send_pixel(rgbh_pkg::pixel_t p);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
	endtask

	// Checker: busy and strobe are sampled at the edge, so the accepted
	// pixel is the value held just before it.
	always @(posedge clk) begin
		rgbh_pkg::hsl_t want;
		if (arst_n) begin
			if (start && !busy) begin
				hsl_pending.push_back(convert_pixel(pixel));
			end
			if (strobe) begin
				if (hsl_pending.size() == 0) begin
					report_mismatch("unexpected result, hue", 32'(result.hue_out), 0);
				end else begin
					want = hsl_pending.pop_front();
					if (result.hue_out !== want.hue_out)
						report_mismatch("hue", 32'(result.hue_out), 32'(want.hue_out));
					if (result.saturation_out !== want.saturation_out)
						report_mismatch("saturation", 32'(result.saturation_out),
							32'(want.saturation_out));
					if (result.lightness_out !== want.lightness_out)
						report_mismatch("lightness", 32'(result.lightness_out),
							32'(want.lightness_out));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned burst;
		int unsigned gap;
		int unsigned sent;
		int unsigned kind;
		rgbh_pkg::pixel_t p;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		error_count = 0;

		// Known rows: black, white, primaries, secondaries and mid grey.
		add_row(8'd0, 8'd0, 8'd0, 1'b1, 0, 0, 0);
		add_row(8'd255, 8'd255, 8'd255, 1'b1, 0, 0, 65535);
		add_row(8'd255, 8'd0, 8'd0, 1'b1, 0, 65535, 32767);
		add_row(8'd0, 8'd255, 8'd0, 1'b1, 7680, 65535, 32767);
		add_row(8'd0, 8'd0, 8'd255, 1'b1, 15360, 65535, 32767);
		add_row(8'd255, 8'd255, 8'd0, 1'b1, 3840, 65535, 32767);
		add_row(8'd0, 8'd255, 8'd255, 1'b1, 11520, 65535, 32767);
		add_row(8'd255, 8'd0, 8'd255, 1'b1, 19200, 65535, 32767);
		add_row(8'd128, 8'd128, 8'd128, 1'b1, 0, 0, 32896);
		// Ties, hue wrap, one-step deltas, the sum near full scale and mixed colours.
		add_row(8'd200, 8'd10, 8'd11, 1'b0, 0, 0, 0);
		add_row(8'd255, 8'd0, 8'd1, 1'b0, 0, 0, 0);
		add_row(8'd1, 8'd0, 8'd0, 1'b0, 0, 0, 0);
		add_row(8'd0, 8'd1, 8'd1, 1'b0, 0, 0, 0);
		add_row(8'd255, 8'd254, 8'd255, 1'b0, 0, 0, 0);
		add_row(8'd128, 8'd127, 8'd127, 1'b0, 0, 0, 0);
		add_row(8'd127, 8'd128, 8'd127, 1'b0, 0, 0, 0);
		add_row(8'd100, 8'd200, 8'd50, 1'b0, 0, 0, 0);
		add_row(8'd30, 8'd60, 8'd250, 1'b0, 0, 0, 0);
		add_row(8'd170, 8'd85, 8'd0, 1'b0, 0, 0, 0);
		add_row(8'd85, 8'd170, 8'd170, 1'b0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].known &&
					convert_pixel(stim_table[i].pix) !== stim_table[i].hsl) begin
				report_mismatch("table row", i, 0);
			end
			send_pixel(stim_table[i].pix);
		end

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && sent < N_RANDOM) begin
				kind = $urandom_range(0, 9);
				p.red_in = 8'($urandom);
				p.green_in = 8'($urandom);
				p.blue_in = 8'($urandom);
				if (kind == 0) begin
					p.green_in = p.red_in;
				end else if (kind == 1) begin
					p.blue_in = p.red_in;
					p.green_in = p.red_in;
				end else if (kind == 2) begin
					p.blue_in = p.green_in;
				end else if (kind == 3) begin
					p.red_in = $urandom_range(0, 3) == 0 ? 8'd255 : 8'd0;
					p.green_in = p.red_in ^ 8'($urandom_range(0, 3));
				end
				send_pixel(p);
				burst--;
				sent++;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		while (hsl_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/rgbh_pkg.sv
rtl/rgbh_div_cell.sv
rtl/rgb_to_hsl_converter.sv
tb/sv/tb_top.sv
